### design/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// shared constants and types for the temperature sensor scratchpad checker
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
    localparam logic [7:0] CFG_MASK      = 8'h9F;
    localparam logic [7:0] CFG_FORM      = 8'h1F;
    localparam logic [7:0] CFG_RES9      = 8'h1F;
    localparam logic [7:0] CFG_RES10     = 8'h3F;
    localparam logic [7:0] CFG_RES11     = 8'h5F;

    localparam logic [3:0] RES_9BIT  = 4'd9;
    localparam logic [3:0] RES_10BIT = 4'd10;
    localparam logic [3:0] RES_11BIT = 4'd11;
    localparam logic [3:0] RES_12BIT = 4'd12;

    // scratchpad byte positions
    localparam logic [3:0] POS_TEMP_LO = 4'd0;
    localparam logic [3:0] POS_TEMP_HI = 4'd1;
    localparam logic [3:0] POS_CONFIG  = 4'd4;
    localparam logic [3:0] POS_CRC     = 4'd8;
    localparam logic [3:0] POS_IDLE    = 4'd9;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } tsc_item_t;

    typedef struct packed {
        logic [7:0]         computed_crc;
        logic signed [15:0] raw_temperature;
        logic [3:0]         resolution_bits;
        logic               reading_valid;
        logic               config_legal;
        logic               crc_match;
    } tsc_result_t;

endpackage

### design/tsc_crc8.sv
// ----------------------------------------------------------------------------
// tsc_crc8
// one-byte update of the reflected 1-wire crc-8, lsb first
// ----------------------------------------------------------------------------
module tsc_crc8 (
    input  logic [7:0] crc_in,
    input  logic [7:0] data_in,
    output logic [7:0] crc_out
);

    always_comb begin
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data_in;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ tsc_pkg::CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        crc_out = c;
    end

endmodule

### design/tsc_frame_tracker.sv
// ----------------------------------------------------------------------------
// tsc_frame_tracker
// frame position, running crc and kept bytes; builds the result on byte 8
// ----------------------------------------------------------------------------
module tsc_frame_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  tsc_pkg::tsc_item_t   item,
    output logic                 emit,
    output tsc_pkg::tsc_result_t result
);

    logic [7:0] crc_reg, crc_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] temp_lo_reg, temp_lo_next;
    logic [7:0] temp_hi_reg, temp_hi_next;
    logic [7:0] config_reg, config_next;

    logic [7:0] crc_cur;
    logic [3:0] pos_cur;
    logic [7:0] crc_upd;
    logic       crc_match;
    logic       config_legal;

    // a frame start restarts the crc and the position
    assign crc_cur = item.frame_start ? 8'h00 : crc_reg;
    assign pos_cur = item.frame_start ? tsc_pkg::POS_TEMP_LO : pos_reg;

    tsc_crc8 u_crc8 (
        .crc_in  (crc_cur),
        .data_in (item.data_byte),
        .crc_out (crc_upd)
    );

    assign crc_match    = (crc_cur == item.data_byte);
    assign config_legal = ((config_reg & tsc_pkg::CFG_MASK) == tsc_pkg::CFG_FORM);

    always_comb begin
        crc_next     = crc_reg;
        pos_next     = pos_reg;
        temp_lo_next = temp_lo_reg;
        temp_hi_next = temp_hi_reg;
        config_next  = config_reg;
        emit         = 1'b0;
        if (step) begin
            crc_next = crc_cur;
            if (pos_cur < tsc_pkg::POS_CRC) begin
                crc_next = crc_upd;
                pos_next = pos_cur + 4'd1;
                case (pos_cur)
                    tsc_pkg::POS_TEMP_LO: temp_lo_next = item.data_byte;
                    tsc_pkg::POS_TEMP_HI: temp_hi_next = item.data_byte;
                    tsc_pkg::POS_CONFIG:  config_next  = item.data_byte;
                    default: ;
                endcase
            end else begin
                emit     = (pos_cur == tsc_pkg::POS_CRC);
                pos_next = tsc_pkg::POS_IDLE;
            end
        end
    end

    always_comb begin
        result.crc_match       = crc_match;
        result.config_legal    = config_legal;
        result.reading_valid   = crc_match & config_legal;
        result.raw_temperature = {temp_hi_reg, temp_lo_reg};
        result.computed_crc    = crc_cur;
        case (config_reg)
            tsc_pkg::CFG_RES9:  result.resolution_bits = tsc_pkg::RES_9BIT;
            tsc_pkg::CFG_RES10: result.resolution_bits = tsc_pkg::RES_10BIT;
            tsc_pkg::CFG_RES11: result.resolution_bits = tsc_pkg::RES_11BIT;
            default:            result.resolution_bits = tsc_pkg::RES_12BIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= 8'h00;
            pos_reg     <= 4'd0;
            temp_lo_reg <= 8'h00;
            temp_hi_reg <= 8'h00;
            config_reg  <= 8'h00;
        end else begin
            crc_reg     <= crc_next;
            pos_reg     <= pos_next;
            temp_lo_reg <= temp_lo_next;
            temp_hi_reg <= temp_hi_next;
            config_reg  <= config_next;
        end
    end

endmodule

### design/temp_sensor_scratchpad_checker_top.sv
// ----------------------------------------------------------------------------
// temp_sensor_scratchpad_checker_top
// checks nine-byte sensor scratchpad frames: crc-8, config form, temperature
// ----------------------------------------------------------------------------
// path: byte 8 waits in the input register, its result in the result register
// throughput: one byte per cycle unless m_tready holds a result; the crc update
//   and frame tracking are combinational between the input and result registers
// reset: synchronous active-low aresetn clears the valid flags, the crc,
//   the byte position and the kept bytes
// ----------------------------------------------------------------------------
module temp_sensor_scratchpad_checker_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tsc_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  logic                             s_tuser,  // [0] frame_start
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] crc_match, [1] config_legal, [2] reading_valid,
    // [6:3] resolution_bits, [22:7] raw_temperature, [30:23] computed_crc,
    // [31] zero
    output logic [tsc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // input register stage
    logic                 in_valid_reg, in_valid_next;
    tsc_pkg::tsc_item_t   in_item_reg;

    // result register stage
    logic                 out_valid_reg, out_valid_next;
    tsc_pkg::tsc_result_t out_result_reg;

    logic                 out_free;
    logic                 step;
    logic                 emit;
    tsc_pkg::tsc_result_t result;

    // the result register can take a new value when empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    // the buffered request moves through the tracker when the output has room
    assign step     = in_valid_reg && out_free;
    // accept a new request whenever the input register empties this cycle
    assign s_tready = !in_valid_reg || out_free;

    tsc_frame_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .emit    (emit),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = step && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.data_byte   <= s_tdata;
            in_item_reg.frame_start <= s_tuser;
        end
        if (step && emit) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_result_reg};

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sensor scratchpad checker: nine-byte frames go
// in with random gaps and back-pressure, a local crc-8 tracker predicts each
// frame result, and every returned result is compared field by field
// ----------------------------------------------------------------------------
module tb_top;

    import tsc_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte
    logic                   s_tuser = 1'b0; // [0] frame_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [0] crc_match, [1] config_legal, [2] reading_valid, [6:3] resolution_bits,
    // [22:7] raw_temperature, [30:23] computed_crc, [31] zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    temp_sensor_scratchpad_checker_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // local copy of the frame tracker
    logic [7:0] frame_crc = '0;
    logic [3:0] next_pos  = '0;
    logic [7:0] kept_lo   = '0;
    logic [7:0] kept_hi   = '0;
    logic [7:0] kept_cfg  = '0;

    tsc_result_t pending_readings[$];

    int  mismatches  = 0;
    int  bytes_taken = 0;
    bit  src_idle    = 1'b1;
    bit  sink_idle   = 1'b1;
    int  sink_stall  = 0;

    logic [7:0] frame_buf [0:8];

    function automatic logic [7:0] crc8_maxim_byte(input logic [7:0] crc_in,
                                                   input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY_REFL;
        end
        return c;
    endfunction

    // mostly short gaps, a few long ones; none while idling is off
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // advance the tracker by one accepted byte; queue a reading on byte 8
    task automatic track_scratchpad_byte(input logic [7:0] b, input logic first,
                                         output bit used);
        tsc_result_t want;
        used = 1'b1;
        if (first) begin
            frame_crc = '0;
            next_pos  = POS_TEMP_LO;
        end
        if (next_pos < POS_CRC) begin
            frame_crc = crc8_maxim_byte(frame_crc, b);
            case (next_pos)
                POS_TEMP_LO: kept_lo = b;
                POS_TEMP_HI: kept_hi = b;
                POS_CONFIG:  kept_cfg = b;
                default: ;
            endcase
            next_pos = next_pos + 4'd1;
        end else if (next_pos == POS_CRC) begin
            want.crc_match     = (frame_crc == b);
            want.config_legal  = ((kept_cfg & CFG_MASK) == CFG_FORM);
            want.reading_valid = want.crc_match & want.config_legal;
            if (kept_cfg == CFG_RES9)       want.resolution_bits = RES_9BIT;
            else if (kept_cfg == CFG_RES10) want.resolution_bits = RES_10BIT;
            else if (kept_cfg == CFG_RES11) want.resolution_bits = RES_11BIT;
            else                            want.resolution_bits = RES_12BIT;
            want.raw_temperature = {kept_hi, kept_lo};
            want.computed_crc    = frame_crc;
            pending_readings.push_back(want);
            next_pos = POS_IDLE;
        end else begin
            // idle: byte dropped until the next frame start
            used     = 1'b0;
            next_pos = POS_IDLE;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // one request on the input channel; valid stays up when no gap follows
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        bit used;
        gap = pick_gap(src_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_scratchpad_byte(b, first, used);
        if (used) bytes_taken++;
    endtask

    // fill frame_buf with one scratchpad; byte 8 is the crc or a corrupted one
    task automatic build_frame(input logic [15:0] temp, input logic [7:0] cfg,
                               input bit good_crc);
        logic [7:0] c;
        frame_buf[0] = temp[7:0];
        frame_buf[1] = temp[15:8];
        frame_buf[2] = 8'($urandom_range(0, 255));
        frame_buf[3] = 8'($urandom_range(0, 255));
        frame_buf[4] = cfg;
        for (int i = 5; i < 8; i++) frame_buf[i] = 8'($urandom_range(0, 255));
        c = '0;
        for (int i = 0; i < 8; i++) c = crc8_maxim_byte(c, frame_buf[i]);
        frame_buf[8] = good_crc ? c : (c ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic send_frame(input int len, input bit flag_first);
        for (int i = 0; i < len; i++) send_byte(frame_buf[i], flag_first && (i == 0));
    endtask

    // result side: random back-pressure, then compare against the oldest reading
    always @(posedge aclk) begin
        tsc_result_t got;
        tsc_result_t want;
        int          g;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = pending_readings.pop_front();
                got  = tsc_result_t'(m_tdata[30:0]);
                if (got.crc_match !== want.crc_match)
                    report_mismatch("crc_match", got.crc_match, want.crc_match);
                if (got.config_legal !== want.config_legal)
                    report_mismatch("config_legal", got.config_legal, want.config_legal);
                if (got.reading_valid !== want.reading_valid)
                    report_mismatch("reading_valid", got.reading_valid,
                                    want.reading_valid);
                if (got.resolution_bits !== want.resolution_bits)
                    report_mismatch("resolution_bits", got.resolution_bits,
                                    want.resolution_bits);
                if (got.raw_temperature !== want.raw_temperature)
                    report_mismatch("raw_temperature", got.raw_temperature,
                                    want.raw_temperature);
                if (got.computed_crc !== want.computed_crc)
                    report_mismatch("computed_crc", got.computed_crc, want.computed_crc);
                if (m_tdata[31] !== 1'b0)
                    report_mismatch("pad bit", m_tdata[31], 0);
            end
        end
        if (sink_stall != 0) begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            g = pick_gap(sink_idle);
            if (g == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                sink_stall <= g - 1;
            end
        end
    end

    // first frame after reset is taken even without the start flag
    task automatic test_first_frame_without_start();
        build_frame(16'h8000, 8'h7F, 1'b1);
        send_frame(9, 1'b0);
    endtask

    // a start flag in the middle drops the frame in progress
    task automatic test_restart_mid_frame();
        build_frame(16'h0000, CFG_RES9, 1'b1);
        send_frame(3, 1'b1);
        build_frame(16'h7FFF, CFG_RES10, 1'b1);
        send_frame(9, 1'b1);
    endtask

    // bytes after the crc byte give nothing
    task automatic test_bytes_past_crc();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // top bit set in config and a corrupted crc
    task automatic test_illegal_config();
        build_frame(16'hFFFF, 8'h9F, 1'b0);
        send_frame(9, 1'b1);
    endtask

    // mostly whole frames with random content, some cut short, some noise
    task automatic test_random_frames(input int target);
        int         r;
        int         phase;
        logic [15:0] temp;
        logic [7:0]  cfg;
        phase = 0;
        while (bytes_taken < target) begin
            // cycle through idling on both sides, one side only, and none
            if (bytes_taken >= (phase + 1) * 240) begin
                phase++;
                src_idle  = (phase % 4) != 1 && (phase % 4) != 3;
                sink_idle = (phase % 4) != 2 && (phase % 4) != 3;
            end
            r = $urandom_range(0, 9);
            case (r)
                0:       temp = 16'h0000;
                1:       temp = 16'hFFFF;
                2:       temp = {$urandom_range(0, 1) ? 8'h7F : 8'h80, 8'($urandom)};
                default: temp = 16'($urandom);
            endcase
            r = $urandom_range(0, 9);
            case (r)
                0, 1:    cfg = CFG_RES9;
                2, 3:    cfg = CFG_RES10;
                4, 5:    cfg = CFG_RES11;
                6:       cfg = 8'h7F;
                7:       cfg = 8'h9F | 8'($urandom_range(0, 255) & 8'h60);
                default: cfg = 8'($urandom);
            endcase
            r = $urandom_range(0, 99);
            if (r < 78) begin
                build_frame(temp, cfg, $urandom_range(0, 3) != 0);
                send_frame(9, 1'b1);
            end else if (r < 88) begin
                build_frame(temp, cfg, 1'b1);
                send_frame($urandom_range(1, 8), 1'b1);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_frame_without_start();
        test_restart_mid_frame();
        test_bytes_past_crc();
        test_illegal_config();
        test_random_frames(1950);

        s_tvalid <= 1'b0;

        // drain: wait for outstanding readings, then watch for stray results
        for (int i = 0; i < 5000 && pending_readings.size() != 0; i++)
            @(posedge aclk);
        if (pending_readings.size() != 0)
            report_mismatch("readings never returned", pending_readings.size(), 0);
        repeat (10) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
